FILE: sv/ssff_pkg.sv
// Package for the seven-segment frame formatter: word types, frame constants,
// reciprocal constants for the decimal split, and the segment code table.
// No dependencies.
package ssff_pkg;

    // Number of decimal values carried in one request (1 or 2).
    localparam int VALUE_COUNT = 2;

    // Frame layout: address word, eight words per value, command word.
    localparam int VALUE_WORDS = 8;
    localparam int FRAME_MAX   = 2 + VALUE_WORDS * VALUE_COUNT;
    localparam int LEN_W       = $clog2(FRAME_MAX + 1);
    localparam int EMIT_W      = $clog2(VALUE_COUNT + 1);

    // Fixed bytes of the frame.
    localparam logic [7:0] ADDR_BYTE = 8'hC0;
    localparam logic [7:0] MINUS_SEG = 8'h40;
    localparam logic [7:0] DOT_SEG   = 8'h80;
    localparam logic [7:0] CMD_BASE  = 8'h80;
    localparam logic [15:0] NEG_LIMIT = 16'd2000;

    // Word kinds.
    localparam logic [1:0] KIND_ADDR = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_CMD  = 2'd2;

    // Exact division of a 16-bit value by 10, 100 and 1000 as
    // floor(x * MUL / 2^SHIFT); each MUL is rounded up and its error stays
    // small enough over the whole 16-bit range.
    localparam int PROD_W       = 40;
    localparam int DIV10_MUL    = 52429;
    localparam int DIV10_SHIFT  = 19;
    localparam int DIV100_MUL   = 167773;
    localparam int DIV100_SHIFT = 24;
    localparam int DIV1K_MUL    = 67109;
    localparam int DIV1K_SHIFT  = 26;
    localparam int Q1_W = 13;  // up to 6553
    localparam int Q2_W = 10;  // up to 655
    localparam int Q3_W = 7;   // up to 65

    // One request.
    typedef struct packed {
        logic [15:0] first_magnitude;
        logic        first_negative;
        logic [2:0]  first_point;
        logic [15:0] second_magnitude;
        logic        second_negative;
        logic [2:0]  second_point;
        logic [7:0]  brightness_level;
        logic        display_on;
    } t_in_word;

    // One frame word.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [1:0] byte_kind;
        logic       frame_end;
    } t_out_word;

    // Mirrored segment code of a decimal digit.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h72;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h31;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7B;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/seven_segment_frame_formatter.sv
// Seven-segment frame formatter: turns one request into a display frame word stream.
// A request passes the input register, then the quotient, frame and output registers,
// before its address word is presented at the output.
// Throughput: one request per 2 + 8*n output words, n the values shown (18 at most);
// the frame shift register and its single output port set that figure.
// Reset (i_rst_n low, synchronous) empties every stage; no other state is kept.
module seven_segment_frame_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssff_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssff_pkg::t_out_word o_out_word
);
    import ssff_pkg::*;

    // Pick the fields of one value out of a request.
    function automatic logic [15:0] get_mag(input t_in_word w, input int v);
        return (v == 0) ? w.first_magnitude : w.second_magnitude;
    endfunction

    function automatic logic get_neg(input t_in_word w, input int v);
        return (v == 0) ? w.first_negative : w.second_negative;
    endfunction

    function automatic logic [2:0] get_pt(input t_in_word w, input int v);
        return (v == 0) ? w.first_point : w.second_point;
    endfunction

    // Stage registers.
    logic            r_s1_valid;
    t_in_word        r_s1;
    logic            r_s2_valid;
    t_in_word        r_s2;
    logic [Q1_W-1:0] r_q1 [VALUE_COUNT];
    logic [Q2_W-1:0] r_q2 [VALUE_COUNT];
    logic [Q3_W-1:0] r_q3 [VALUE_COUNT];
    logic [7:0]      r_frm [FRAME_MAX];
    logic [LEN_W-1:0] r_frm_left;
    logic            r_frm_first;
    logic            r_out_valid;
    t_out_word       r_out;

    logic [Q1_W-1:0] n_q1 [VALUE_COUNT];
    logic [Q2_W-1:0] n_q2 [VALUE_COUNT];
    logic [Q3_W-1:0] n_q3 [VALUE_COUNT];
    logic [7:0]      n_frm [FRAME_MAX];
    logic [LEN_W-1:0] n_len;
    t_out_word       n_out;

    logic pop;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;

    // Handshake between the stages: each stage takes a new word when it is
    // empty or when its own word moves on in the same cycle.
    assign pop      = (r_frm_left != '0) && (!r_out_valid || i_out_ready);
    assign s3_ready = (r_frm_left == '0) || ((r_frm_left == LEN_W'(1)) && pop);
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign o_in_ready  = s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Quotients by 10, 100 and 1000 through reciprocal multiplication.
    always_comb begin
        logic [PROD_W-1:0] p10;
        logic [PROD_W-1:0] p100;
        logic [PROD_W-1:0] p1k;
        for (int v = 0; v < VALUE_COUNT; v++) begin
            p10     = PROD_W'(get_mag(r_s1, v)) * PROD_W'(DIV10_MUL);
            p100    = PROD_W'(get_mag(r_s1, v)) * PROD_W'(DIV100_MUL);
            p1k     = PROD_W'(get_mag(r_s1, v)) * PROD_W'(DIV1K_MUL);
            n_q1[v] = p10[DIV10_SHIFT +: Q1_W];
            n_q2[v] = p100[DIV100_SHIFT +: Q2_W];
            n_q3[v] = p1k[DIV1K_SHIFT +: Q3_W];
        end
    end

    // Frame assembly: digits from the quotients, segment codes, dots,
    // minus sign, early end on a large negative value, command word.
    always_comb begin
        logic [15:0]      mag;
        logic             neg;
        logic [2:0]       pt;
        logic [3:0]       dig0;
        logic [3:0]       dig1;
        logic [3:0]       dig2;
        logic [3:0]       top;
        logic [7:0]       d;
        logic             alive;
        logic [EMIT_W-1:0] emit;
        logic [2:0]       bright;
        logic [7:0]       cmd;
        for (int i = 0; i < FRAME_MAX; i++) begin
            n_frm[i] = 8'h00;
        end
        n_frm[0] = ADDR_BYTE;
        alive = 1'b1;
        emit  = '0;
        for (int v = 0; v < VALUE_COUNT; v++) begin
            mag  = get_mag(r_s2, v);
            neg  = get_neg(r_s2, v);
            pt   = get_pt(r_s2, v);
            dig0 = 4'(mag - (16'(r_q1[v]) * 16'd10));
            dig1 = 4'(r_q1[v] - (Q1_W'(r_q2[v]) * Q1_W'(10)));
            dig2 = 4'(r_q2[v] - (Q2_W'(r_q3[v]) * Q2_W'(10)));
            top  = (r_q3[v] > Q3_W'(9)) ? 4'd9 : 4'(r_q3[v]);

            // Units and tens.
            d = seg_code(dig0) | ((pt == 3'd1) ? DOT_SEG : 8'h00);
            n_frm[1 + VALUE_WORDS * v] = d;
            d = seg_code(dig1) | ((pt == 3'd2) ? DOT_SEG : 8'h00);
            n_frm[3 + VALUE_WORDS * v] = d;

            // Hundreds are blank when no dot position is given.
            if (pt != 3'd0) begin
                d = seg_code(dig2) | ((pt == 3'd3) ? DOT_SEG : 8'h00);
            end else begin
                d = 8'h00;
            end
            n_frm[5 + VALUE_WORDS * v] = d;

            // Top digit carries the minus sign by addition.
            if (r_q3[v] != '0) begin
                d = seg_code(top) | ((pt == 3'd4) ? DOT_SEG : 8'h00);
                if (neg) begin
                    d = d + MINUS_SEG;
                end
            end else if (neg) begin
                d = MINUS_SEG;
            end else begin
                d = 8'h00;
            end
            n_frm[7 + VALUE_WORDS * v] = d;

            // A large negative value stops this and all later values.
            alive = alive && !(neg && (mag >= NEG_LIMIT));
            if (alive) begin
                emit = EMIT_W'(v + 1);
            end
        end

        // Command word with the brightness held to 1..7.
        if (r_s2.brightness_level > 8'd7) begin
            bright = 3'd7;
        end else if (r_s2.brightness_level == 8'd0) begin
            bright = 3'd1;
        end else begin
            bright = r_s2.brightness_level[2:0];
        end
        cmd = CMD_BASE | {4'b0000, r_s2.display_on, 3'b000} | {5'b00000, bright};
        for (int k = 0; k <= VALUE_COUNT; k++) begin
            if (emit == EMIT_W'(k)) begin
                n_frm[1 + VALUE_WORDS * k] = cmd;
            end
        end
        n_len = LEN_W'(2 + VALUE_WORDS * int'(emit));
    end

    // Word kind follows from the place in the frame.
    always_comb begin
        n_out.frame_byte = r_frm[0];
        n_out.frame_end  = (r_frm_left == LEN_W'(1));
        if (r_frm_first) begin
            n_out.byte_kind = KIND_ADDR;
        end else if (r_frm_left == LEN_W'(1)) begin
            n_out.byte_kind = KIND_CMD;
        end else begin
            n_out.byte_kind = KIND_DATA;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_frm_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready && r_s2_valid) begin
                r_frm_left <= n_len;
            end else if (pop) begin
                r_frm_left <= r_frm_left - LEN_W'(1);
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1 <= i_in_word;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= r_s1;
            r_q1 <= n_q1;
            r_q2 <= n_q2;
            r_q3 <= n_q3;
        end
        if (s3_ready && r_s2_valid) begin
            r_frm       <= n_frm;
            r_frm_first <= 1'b1;
        end else if (pop) begin
            for (int i = 0; i < FRAME_MAX - 1; i++) begin
                r_frm[i] <= r_frm[i + 1];
            end
            r_frm[FRAME_MAX - 1] <= 8'h00;
            r_frm_first          <= 1'b0;
        end
        if (pop) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: sv/ssff_checker.sv
// Port checker for the seven-segment frame formatter, attached by bind.
// Depends on ssff_pkg for word types and frame constants.
module ssff_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ssff_pkg::t_out_word o_out_word
);
    import ssff_pkg::*;

    logic in_acc;
    logic out_acc;
    logic [3:0] r_pend;
    logic r_start;
    logic [LEN_W-1:0] r_pos;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Requests whose frames are not finished, and the place in the current frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_start <= 1'b1;
            r_pos   <= '0;
        end else begin
            r_pend <= r_pend + 4'(in_acc) - 4'(out_acc && o_out_word.frame_end);
            if (out_acc) begin
                r_start <= o_out_word.frame_end;
                r_pos   <= o_out_word.frame_end ? '0 : r_pos + LEN_W'(1);
            end
        end
    end

    // A frame only closes for a request that was taken.
    a_no_extra_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_word.frame_end |-> r_pend != '0)
        else $error("frame closed with no request pending");

    // The address word opens every frame and only there.
    a_addr_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> ((o_out_word.byte_kind == KIND_ADDR) == r_start))
        else $error("address word out of place");

    // A frame closes after the address word and whole values.
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_word.frame_end |->
            (r_pos[2:0] == 3'd1) && (int'(r_pos) <= FRAME_MAX - 1)
            && (o_out_word.byte_kind == KIND_CMD))
        else $error("frame of wrong length");

    // A waiting word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

endmodule

bind seven_segment_frame_formatter ssff_checker u_ssff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

FILE: test/seven_segment_frame_formatter_tb.sv
// Self-checking testbench for the seven-segment frame formatter: random-paced request
// driver, result monitor with random stalls, and a word-level frame predictor.
// Depends on ssff_pkg (word types and frame constants) and the formatter RTL.
module seven_segment_frame_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssff_pkg::*;

    localparam int     CLK_HALF_NS     = 5;
    localparam int     RESET_CYCLES    = 3;
    localparam int     RANDOM_REQUESTS = 470;
    localparam int     MAX_WAIT        = 12;
    localparam int     REPORT_LIMIT    = 10;
    localparam int     DRAIN_CYCLES    = 16;
    localparam longint RUN_LIMIT_NS    = 5_000_000;

    // Pacing styles; each side switches style after 8 to 40 of its own accepted words.
    typedef enum int unsigned {
        PACE_STEADY,
        PACE_LIGHT,
        PACE_HEAVY
    } t_pace;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_word   in_word  = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_word  out_word;

    t_in_word    requests_pending[$];
    t_out_word   frame_words_due[$];
    int unsigned mismatch_count = 0;
    int unsigned words_seen     = 0;
    int unsigned requests_sent  = 0;

    int unsigned send_gap        = 0;
    t_pace       send_style      = PACE_STEADY;
    int unsigned send_style_left = 0;
    int unsigned take_stall      = 0;
    t_pace       take_style      = PACE_STEADY;
    int unsigned take_style_left = 0;

    seven_segment_frame_formatter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // Clock and a single reset pulse at the start of the run.
    initial begin
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Mirrored segment pattern of one decimal digit.
    function automatic logic [7:0] glyph_of(input int unsigned digit);
        case (digit)
            0:       return 8'h3F;
            1:       return 8'h30;
            2:       return 8'h6D;
            3:       return 8'h79;
            4:       return 8'h72;
            5:       return 8'h5B;
            6:       return 8'h5F;
            7:       return 8'h31;
            8:       return 8'h7F;
            default: return 8'h7B;
        endcase
    endfunction

    function automatic void push_due(input logic [7:0] value, input logic [1:0] kind,
                                     input logic last);
        t_out_word w;
        w.frame_byte = value;
        w.byte_kind  = kind;
        w.frame_end  = last;
        frame_words_due.push_back(w);
    endfunction

    // Expected frame for one request: address, eight words per shown value, command.
    function automatic void predict_frame(input t_in_word req);
        logic [15:0] mag [2];
        logic        neg [2];
        logic [2:0]  dot [2];
        logic [7:0]  digit_byte [4];
        int unsigned top;
        int unsigned level;
        mag[0] = req.first_magnitude;
        neg[0] = req.first_negative;
        dot[0] = req.first_point;
        mag[1] = req.second_magnitude;
        neg[1] = req.second_negative;
        dot[1] = req.second_point;
        push_due(ADDR_BYTE, KIND_ADDR, 1'b0);
        for (int v = 0; v < VALUE_COUNT; v++) begin
            // A large negative value cuts the frame short, later values included.
            if (neg[v] && mag[v] >= NEG_LIMIT) break;
            digit_byte[0] = glyph_of(mag[v] % 10) | ((dot[v] == 3'd1) ? DOT_SEG : 8'h00);
            digit_byte[1] = glyph_of((mag[v] / 10) % 10)
                          | ((dot[v] == 3'd2) ? DOT_SEG : 8'h00);
            if (dot[v] != 3'd0) begin
                digit_byte[2] = glyph_of((mag[v] / 100) % 10)
                              | ((dot[v] == 3'd3) ? DOT_SEG : 8'h00);
            end else begin
                digit_byte[2] = 8'h00;
            end
            // Top digit saturates at nine; a minus sign is added onto a top digit of one.
            if (mag[v] >= 16'd1000) begin
                top = mag[v] / 1000;
                if (top > 9) top = 9;
                digit_byte[3] = glyph_of(top) | ((dot[v] == 3'd4) ? DOT_SEG : 8'h00);
                if (neg[v]) digit_byte[3] = digit_byte[3] + MINUS_SEG;
            end else begin
                digit_byte[3] = neg[v] ? MINUS_SEG : 8'h00;
            end
            for (int d = 0; d < 4; d++) begin
                push_due(digit_byte[d], KIND_DATA, 1'b0);
                push_due(8'h00, KIND_DATA, 1'b0);
            end
        end
        level = req.brightness_level;
        if (level > 7) level = 7;
        if (level < 1) level = 1;
        push_due(CMD_BASE | {4'b0000, req.display_on, 3'b000} | level[7:0], KIND_CMD, 1'b1);
    endfunction

    function automatic int unsigned pick_wait(input t_pace style);
        case (style)
            PACE_STEADY: return 0;
            PACE_LIGHT:  return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
            default:     return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic logic [15:0] random_magnitude();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 999));
            2:       return 16'($urandom_range(1000, 2999));
            3:       return 16'($urandom_range(1990, 2010));
            default: return 16'($urandom_range(0, 9999));
        endcase
    endfunction

    function automatic void add_request(input logic [15:0] m1, input logic n1,
                                        input logic [2:0] p1, input logic [15:0] m2,
                                        input logic n2, input logic [2:0] p2,
                                        input logic [7:0] bright, input logic on);
        t_in_word req;
        req.first_magnitude  = m1;
        req.first_negative   = n1;
        req.first_point      = p1;
        req.second_magnitude = m2;
        req.second_negative  = n2;
        req.second_point     = p2;
        req.brightness_level = bright;
        req.display_on       = on;
        requests_pending.push_back(req);
    endfunction

    // Request driver: after each accepted word it idles for a drawn number of cycles.
    always @(posedge i_clk) begin
        int unsigned wait_n;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            wait_n = send_gap;
            if (in_valid && in_ready) begin
                predict_frame(in_word);
                requests_sent++;
                if (send_style_left == 0) begin
                    send_style      = t_pace'($urandom_range(0, 2));
                    send_style_left = $urandom_range(8, 40);
                end
                send_style_left--;
                wait_n = pick_wait(send_style);
            end
            if (!in_valid || in_ready) begin
                if (wait_n == 0 && requests_pending.size() != 0) begin
                    in_word  <= requests_pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                    if (wait_n != 0) wait_n--;
                end
            end
            send_gap <= wait_n;
        end
    end

    // Frame monitor: checks each accepted word, then stalls for a drawn number of cycles.
    always @(posedge i_clk) begin
        int unsigned stall_n;
        t_out_word   due;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            take_stall <= 0;
        end else begin
            stall_n = take_stall;
            if (out_valid && out_ready) begin
                words_seen++;
                if (frame_words_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("word %0d arrived unexpectedly: byte %02h kind %0d end %0d",
                                 words_seen, out_word.frame_byte, out_word.byte_kind,
                                 out_word.frame_end);
                end else begin
                    due = frame_words_due.pop_front();
                    if (out_word.frame_byte !== due.frame_byte ||
                        out_word.byte_kind  !== due.byte_kind  ||
                        out_word.frame_end  !== due.frame_end) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"word %0d mismatch: expected byte %02h kind %0d end %0d,",
                                      " got byte %02h kind %0d end %0d"},
                                     words_seen, due.frame_byte, due.byte_kind, due.frame_end,
                                     out_word.frame_byte, out_word.byte_kind,
                                     out_word.frame_end);
                    end
                end
                if (take_style_left == 0) begin
                    take_style      = t_pace'($urandom_range(0, 2));
                    take_style_left = $urandom_range(8, 40);
                end
                take_style_left--;
                stall_n = pick_wait(take_style);
            end
            if (stall_n != 0) begin
                out_ready <= 1'b0;
                stall_n--;
            end else begin
                out_ready <= 1'b1;
            end
            take_stall <= stall_n;
        end
    end

    // Stimulus and end of run.
    initial begin
        t_in_word    req;
        int unsigned request_total;
        // Directed requests: field extremes, every dot position, sign and brightness cases.
        add_request(16'd0,     1'b0, 3'd0, 16'd0,     1'b0, 3'd0, 8'd0,   1'b0);
        add_request(16'd65535, 1'b0, 3'd4, 16'd65535, 1'b0, 3'd7, 8'd255, 1'b1);
        add_request(16'd1,     1'b0, 3'd1, 16'd12,    1'b0, 3'd2, 8'd1,   1'b1);
        add_request(16'd123,   1'b0, 3'd3, 16'd1234,  1'b0, 3'd4, 8'd7,   1'b1);
        add_request(16'd9999,  1'b0, 3'd5, 16'd10000, 1'b0, 3'd6, 8'd8,   1'b0);
        add_request(16'd1999,  1'b1, 3'd4, 16'd999,   1'b1, 3'd0, 8'd3,   1'b1);
        add_request(16'd2000,  1'b1, 3'd1, 16'd5,     1'b0, 3'd1, 8'd4,   1'b1);
        add_request(16'd42,    1'b0, 3'd2, 16'd2000,  1'b1, 3'd3, 8'd6,   1'b0);
        add_request(16'd65535, 1'b1, 3'd7, 16'd1,     1'b0, 3'd0, 8'd2,   1'b1);
        add_request(16'd0,     1'b1, 3'd0, 16'd1000,  1'b1, 3'd4, 8'd5,   1'b1);
        add_request(16'd1000,  1'b0, 3'd0, 16'd100,   1'b0, 3'd3, 8'd255, 1'b0);
        add_request(16'd1999,  1'b1, 3'd0, 16'd1998,  1'b1, 3'd2, 8'd0,   1'b1);
        add_request(16'd2001,  1'b0, 3'd1, 16'd3001,  1'b0, 3'd2, 8'd128, 1'b1);
        add_request(16'd4567,  1'b0, 3'd7, 16'd8901,  1'b1, 3'd3, 8'd127, 1'b0);
        add_request(16'd5,     1'b0, 3'd0, 16'd50,    1'b1, 3'd1, 8'd7,   1'b0);
        add_request(16'd32768, 1'b0, 3'd2, 16'd16384, 1'b0, 3'd1, 8'd1,   1'b0);
        add_request(16'd9,     1'b0, 3'd6, 16'd90,    1'b0, 3'd5, 8'd9,   1'b1);
        add_request(16'd1500,  1'b1, 3'd3, 16'd1,     1'b1, 3'd4, 8'd254, 1'b1);
        add_request(16'd9000,  1'b0, 3'd4, 16'd1001,  1'b1, 3'd4, 8'd170, 1'b1);
        add_request(16'd2047,  1'b1, 3'd2, 16'd21845, 1'b0, 3'd3, 8'd85,  1'b0);

        // Random requests, magnitudes weighted toward the digit and sign boundaries.
        repeat (RANDOM_REQUESTS) begin
            req.first_magnitude  = random_magnitude();
            req.first_negative   = ($urandom_range(0, 2) == 0);
            req.first_point      = 3'($urandom_range(0, 7));
            req.second_magnitude = random_magnitude();
            req.second_negative  = ($urandom_range(0, 2) == 0);
            req.second_point     = 3'($urandom_range(0, 7));
            req.brightness_level = $urandom_range(0, 1) ? 8'($urandom_range(0, 9))
                                                        : 8'($urandom_range(0, 255));
            req.display_on       = 1'($urandom_range(0, 1));
            requests_pending.push_back(req);
        end
        request_total = requests_pending.size();

        // Wait for every request to be accepted and every frame word to come out.
        while (requests_sent < request_total || frame_words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (frame_words_due.size() != 0) begin
            $display("%0d expected words never arrived", frame_words_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog in case the handshakes stop moving.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
sv/ssff_pkg.sv
sv/seven_segment_frame_formatter.sv
sv/ssff_checker.sv
test/seven_segment_frame_formatter_tb.sv
